// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level module of the LFO block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(name, clock, reset, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clock, reset, prop, msg)
`define ASSERT_NEVER(name, clock, reset, cond, msg)
`endif

`endif

// ----- hdl/tlfo_pkg.sv -----
// Types and constants shared by the triangle LFO modules.
package tlfo_pkg;

  localparam int AVG_SHIFT    = 5;
  localparam int NUM_CHANNELS = 8;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 10;
  localparam int AVG_W    = 10;
  localparam int SUM_W    = 16;
  localparam int POS_W    = 16;
  localparam int LEFT_W   = AVG_SHIFT + 1;
  localparam int CNT_W    = 16;

  localparam logic [LEFT_W-1:0] BLOCK_SIZE = LEFT_W'(1 << AVG_SHIFT);
  localparam logic [CHAN_W:0]   CHAN_COUNT = (CHAN_W + 1)'(NUM_CHANNELS);

  localparam logic [POS_W-1:0] POS_LIMIT   = 16'd1023;
  localparam logic [POS_W-1:0] MIN_PERIOD  = 16'd4;
  localparam logic [POS_W-1:0] POS_RESET   = 16'd15;
  localparam logic [AVG_W-1:0] DEPTH_RESET = 10'd100;
  localparam logic [AVG_W-1:0] RATE_RESET  = 10'd100;

  // Item kinds.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Converter channels with a fixed role, and the idle channel code.
  localparam logic [CHAN_W-1:0] CH_BASE      = 3'd0;
  localparam logic [CHAN_W-1:0] CH_RATE      = 3'd3;
  localparam logic [CHAN_W-1:0] CH_DEPTH     = 3'd4;
  localparam logic [CHAN_W-1:0] NEXT_CH_IDLE = 3'd0;

  typedef struct packed {
    logic              cmd;
    logic [CHAN_W-1:0] channel;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [15:0]       period;
    logic [14:0]       compare_value;
    logic              period_changed;
    logic [CHAN_W-1:0] next_channel;
  } result_t;

  // Averages of the control channels as they stand after the current item.
  typedef struct packed {
    logic [AVG_W-1:0] base;
    logic [AVG_W-1:0] rate;
    logic [AVG_W-1:0] depth;
  } avg_taps_t;

endpackage

// ----- hdl/tlfo_avg.sv -----
// Per-channel sample accumulators and block averages.
module tlfo_avg
  import tlfo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  item_t     item,
  output avg_taps_t taps
);

  logic [SUM_W-1:0]  sums [NUM_CHANNELS];
  logic [LEFT_W-1:0] left [NUM_CHANNELS];
  logic [AVG_W-1:0]  avgs [NUM_CHANNELS];

  logic [CHAN_W-1:0] ch;
  logic              accum;
  logic [SUM_W-1:0]  sum_next;
  logic [LEFT_W-1:0] left_next;
  logic              done;
  logic [AVG_W-1:0]  avg_new;
  logic              fresh;

  always_comb begin
    ch        = item.channel;
    accum     = (item.cmd == CMD_SAMPLE) && ({1'b0, ch} < CHAN_COUNT);
    sum_next  = sums[ch] + SUM_W'(item.sample);
    left_next = left[ch] - LEFT_W'(1);
    done      = (left_next == '0);
    avg_new   = AVG_W'(sum_next >> AVG_SHIFT);
    fresh     = accum && done;
  end

  // The new average of this transaction is forwarded so that depth, rate and
  // base follow it straight away.
  always_comb begin
    taps.base  = (fresh && ch == CH_BASE)  ? avg_new : avgs[CH_BASE];
    taps.rate  = (fresh && ch == CH_RATE)  ? avg_new : avgs[CH_RATE];
    taps.depth = (fresh && ch == CH_DEPTH) ? avg_new : avgs[CH_DEPTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums[i] <= '0;
        left[i] <= BLOCK_SIZE;
        avgs[i] <= '0;
      end
    end else if (en && accum) begin
      if (done) begin
        avgs[ch] <= avg_new;
        sums[ch] <= '0;
        left[ch] <= BLOCK_SIZE;
      end else begin
        sums[ch] <= sum_next;
        left[ch] <= left_next;
      end
    end
  end

endmodule

// ----- hdl/tlfo_sweep.sv -----
// Sweep state: depth, rate, base, tick counter and triangle position.
module tlfo_sweep
  import tlfo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  item_t            item,
  input  avg_taps_t        taps,
  output logic [POS_W-1:0] pos_next,
  output logic             changed
);

  logic [AVG_W-1:0] depth;
  logic [AVG_W-1:0] rate;
  logic [AVG_W-1:0] base;
  logic [POS_W-1:0] position;
  logic             rising;
  logic [CNT_W-1:0] tick_count;

  logic [AVG_W-1:0] depth_next;
  logic [AVG_W-1:0] rate_next;
  logic [AVG_W-1:0] base_next;
  logic             rising_next;
  logic [CNT_W-1:0] tick_count_next;

  logic [POS_W-1:0] base_wide;
  logic [POS_W-1:0] offset;
  logic [POS_W-1:0] rebased;
  logic [AVG_W:0]   top_sum;
  logic [AVG_W-1:0] top_clamped;
  logic [POS_W-1:0] top;
  logic [CNT_W-1:0] tick_inc;
  logic [CNT_W-1:0] threshold;
  logic             step;
  logic [POS_W-1:0] pos_up;
  logic [POS_W-1:0] pos_down;

  always_comb begin
    base_wide = POS_W'(base);
    offset    = position - base_wide;
    rebased   = POS_W'(taps.base) + offset;

    // Upper turning point, clamped to the position limit and kept above zero.
    top_sum     = {1'b0, base} + {1'b0, depth};
    top_clamped = (top_sum > (AVG_W + 1)'(POS_LIMIT)) ? AVG_W'(POS_LIMIT)
                                                        : top_sum[AVG_W-1:0];
    if (top_clamped == '0) begin
      top_clamped = AVG_W'(1);
    end
    top = POS_W'(top_clamped);

    tick_inc  = tick_count + CNT_W'(1);
    threshold = CNT_W'(POS_LIMIT - POS_W'(rate));
    step      = (rate != '0) && (tick_inc >= threshold);
    pos_up    = position + POS_W'(1);
    pos_down  = position - POS_W'(1);
  end

  always_comb begin
    depth_next      = depth;
    rate_next       = rate;
    base_next       = base;
    pos_next        = position;
    rising_next     = rising;
    tick_count_next = tick_count;
    if (en) begin
      unique case (item.cmd)
        CMD_SAMPLE: begin
          depth_next = taps.depth;
          rate_next  = taps.rate;
          if (taps.base != base) begin
            base_next = taps.base;
            pos_next  = (rebased > POS_LIMIT) ? POS_LIMIT : rebased;
          end
        end
        CMD_TICK: begin
          tick_count_next = tick_inc;
          if (step) begin
            tick_count_next = '0;
            if (rising) begin
              if (pos_up >= top) begin
                pos_next    = top;
                rising_next = 1'b0;
              end else begin
                pos_next = pos_up;
              end
            end else begin
              pos_next = pos_down;
              if (pos_down == '0 || pos_down <= base_wide) begin
                rising_next = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    changed = (pos_next != position);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= DEPTH_RESET;
      rate       <= RATE_RESET;
      base       <= '0;
      position   <= POS_RESET;
      rising     <= 1'b1;
      tick_count <= '0;
    end else begin
      depth      <= depth_next;
      rate       <= rate_next;
      base       <= base_next;
      position   <= pos_next;
      rising     <= rising_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

// ----- hdl/triangle_lfo_with_pot_averaging_unit.sv -----
// Flanger modulation generator: pot averaging and triangle LFO, top level.
//
// Input channel (item_valid / item_stall / item): each transaction is either
// a converter sample (cmd low) for the given channel, or a timer tick.
// Output channel (result_valid / result_stall / result): exactly one result
// per input transaction, in order, carrying the clock period, its half for
// the square-wave compare, a flag for a position change, and the converter
// channel to select next.
// An item passes through an input register and then a result register, and
// all state is updated as it moves between them. One item is taken every
// cycle while the output is not stalled. When the receiver stalls, the
// result register holds, the input register fills and item_stall rises
// until the result is taken. Synchronous reset empties both registers,
// clears the accumulators and averages, restores depth and rate to 100,
// position to 15 and the triangle direction to rising, and clears the
// base and the tick counter.
`include "assert_macros.svh"

module triangle_lfo_with_pot_averaging_unit
  import tlfo_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic      ireg_valid;
  item_t     ireg;
  logic      fire;
  logic      accept;
  avg_taps_t taps;
  logic [POS_W-1:0] pos_next;
  logic      changed;
  logic [POS_W-1:0] period;
  logic [CHAN_W-1:0] next_channel;
  result_t   result_next;

  // A held item moves on whenever the result register is free or emptying.
  assign fire       = ireg_valid && (!result_valid || !result_stall);
  assign item_stall = ireg_valid && !fire;
  assign accept     = item_valid && !item_stall;

  tlfo_avg u_avg (
    .clk  (clk),
    .rst  (rst),
    .en   (fire),
    .item (ireg),
    .taps (taps)
  );

  tlfo_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .en       (fire),
    .item     (ireg),
    .taps     (taps),
    .pos_next (pos_next),
    .changed  (changed)
  );

  always_comb begin
    period = (pos_next < MIN_PERIOD) ? MIN_PERIOD : pos_next;
    if (ireg.cmd == CMD_TICK) begin
      next_channel = NEXT_CH_IDLE;
    end else begin
      unique case (ireg.channel)
        CH_BASE:  next_channel = CH_RATE;
        CH_RATE:  next_channel = CH_DEPTH;
        CH_DEPTH: next_channel = CH_BASE;
        default:  next_channel = ireg.channel;
      endcase
    end
    result_next.period         = period;
    result_next.compare_value  = period[15:1];
    result_next.period_changed = changed;
    result_next.next_channel   = next_channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        ireg_valid <= 1'b1;
      end else if (fire) begin
        ireg_valid <= 1'b0;
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ireg <= item;
    end
    if (fire) begin
      result <= result_next;
    end
  end

  `ASSERT_CLK(a_fire_fills_result, clk, rst, fire |=> result_valid, "moved item lost")
  `ASSERT_NEVER(a_stall_without_item, clk, rst, item_stall && !ireg_valid, "stall with empty input register")
  `ASSERT_CLK(a_period_floor, clk, rst, result_valid |-> (result.period >= MIN_PERIOD), "period below minimum")
  `ASSERT_CLK(a_compare_half, clk, rst, result_valid |-> (result.compare_value == result.period[15:1]), "compare value not half the period")

endmodule

// ----- bench/tb_triangle_lfo_with_pot_averaging_unit.sv -----
// Self-checking testbench for the triangle LFO with pot averaging.
`timescale 1ns / 100ps

module tb_triangle_lfo_with_pot_averaging_unit
  import tlfo_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int stuck_cycles = 0;

  result_t pending_results[$];

  // Mirror of the averaging and oscillator state.
  logic [SUM_W-1:0]  pot_sum  [NUM_CHANNELS];
  logic [LEFT_W-1:0] pot_left [NUM_CHANNELS];
  logic [AVG_W-1:0]  pot_avg  [NUM_CHANNELS];
  logic [AVG_W-1:0]  lfo_depth;
  logic [AVG_W-1:0]  lfo_rate;
  logic [AVG_W-1:0]  lfo_base;
  logic [POS_W-1:0]  lfo_pos;
  logic              lfo_rising;
  logic [CNT_W-1:0]  lfo_ticks;

  triangle_lfo_with_pot_averaging_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic reset_lfo_model();
    int i;
    for (i = 0; i < NUM_CHANNELS; i++) begin
      pot_sum[i] = '0;
      pot_left[i] = BLOCK_SIZE;
      pot_avg[i] = '0;
    end
    lfo_depth = DEPTH_RESET;
    lfo_rate = RATE_RESET;
    lfo_base = '0;
    lfo_pos = POS_RESET;
    lfo_rising = 1'b1;
    lfo_ticks = '0;
  endtask

  function automatic result_t advance_lfo(item_t it);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] per;
    result_t r;
    pos = lfo_pos;
    r = '0;
    if (it.cmd == CMD_SAMPLE) begin
      if (it.channel < NUM_CHANNELS) begin
        pot_sum[it.channel] = pot_sum[it.channel] + SUM_W'(it.sample);
        pot_left[it.channel] = pot_left[it.channel] - 1'b1;
        if (pot_left[it.channel] == '0) begin
          pot_avg[it.channel] = AVG_W'(pot_sum[it.channel] >> AVG_SHIFT);
          pot_sum[it.channel] = '0;
          pot_left[it.channel] = BLOCK_SIZE;
        end
      end
      lfo_depth = pot_avg[CH_DEPTH];
      lfo_rate = pot_avg[CH_RATE];
      // A new base keeps the wrapped distance of the position from the old one.
      if (pot_avg[CH_BASE] != lfo_base) begin
        offset = pos - POS_W'(lfo_base);
        lfo_base = pot_avg[CH_BASE];
        pos = POS_W'(lfo_base) + offset;
        if (pos > POS_LIMIT) pos = POS_LIMIT;
      end
      case (it.channel)
        CH_BASE:  r.next_channel = CH_RATE;
        CH_RATE:  r.next_channel = CH_DEPTH;
        CH_DEPTH: r.next_channel = CH_BASE;
        default:  r.next_channel = it.channel;
      endcase
    end else begin
      top = POS_W'(lfo_base) + POS_W'(lfo_depth);
      if (top > POS_LIMIT) top = POS_LIMIT;
      if (top == '0) top = 16'd1;
      lfo_ticks = lfo_ticks + 1'b1;
      if (lfo_rate != '0 && lfo_ticks >= POS_LIMIT - POS_W'(lfo_rate)) begin
        lfo_ticks = '0;
        if (lfo_rising) begin
          pos = pos + 1'b1;
          if (pos >= top) begin
            pos = top;
            lfo_rising = 1'b0;
          end
        end else begin
          // A fall from zero wraps round and carries on falling.
          pos = pos - 1'b1;
          if (pos == '0 || pos <= POS_W'(lfo_base)) lfo_rising = 1'b1;
        end
      end
      r.next_channel = NEXT_CH_IDLE;
    end
    r.period_changed = (pos != lfo_pos);
    lfo_pos = pos;
    per = (pos < MIN_PERIOD) ? MIN_PERIOD : pos;
    r.period = per;
    r.compare_value = per[15:1];
    return r;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(advance_lfo(it));
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
    send_item('{cmd: CMD_SAMPLE, channel: ch, sample: value});
  endtask

  // Channel and sample carry no meaning on a tick, so they are left random.
  task automatic send_tick();
    send_item('{cmd: CMD_TICK, channel: CHAN_W'($urandom_range(7)),
                sample: SAMPLE_W'($urandom_range(1023))});
  endtask

  task automatic send_noise();
    send_item('{cmd: 1'($urandom_range(1)), channel: CHAN_W'($urandom_range(7)),
                sample: SAMPLE_W'($urandom_range(1023))});
  endtask

  // Completes any partial block on the channel, then a full one at the value.
  task automatic set_pot(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
    while (pot_left[ch] != BLOCK_SIZE) send_sample(ch, value);
    repeat (BLOCK_SIZE) send_sample(ch, value);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_and_extremes();
    int ch;
    send_tick();
    for (ch = 0; ch < NUM_CHANNELS; ch++) begin
      send_sample(CHAN_W'(ch), 10'h3FF);
      send_sample(CHAN_W'(ch), 10'h000);
    end
    send_item('{cmd: CMD_TICK, channel: 3'd7, sample: 10'h3FF});
    send_item('{cmd: CMD_TICK, channel: 3'd0, sample: 10'h000});
    send_sample(3'd5, 10'h155);
    send_sample(3'd2, 10'h2AA);
    send_tick();
  endtask

  // With the rate at zero the tick counter keeps climbing; once a rate is set
  // whose threshold lies below the count, the next tick steps straight away.
  task automatic test_rate_zero_count();
    send_idle_pct = 0;
    stall_pct = 0;
    set_pot(CH_RATE, 10'd0);
    repeat (40) send_tick();
    set_pot(CH_RATE, 10'd1000);
    repeat (30) send_tick();
  endtask

  // Drives the position to zero while falling, so that the next step wraps.
  task automatic test_fall_below_zero();
    int guard;
    set_pot(CH_RATE, 10'd1022);
    set_pot(CH_DEPTH, 10'd1023);
    set_pot(CH_BASE, 10'd1000);
    guard = 0;
    while (!(lfo_pos == POS_LIMIT && !lfo_rising) && guard < 4000) begin
      send_tick();
      guard++;
    end
    set_pot(CH_BASE, 10'd1023);
    set_pot(CH_BASE, 10'd0);
    repeat (3) send_tick();
    set_pot(CH_BASE, 10'd500);
    repeat (6) send_tick();
  endtask

  // Zero base and depth give a top of one and a period held at its minimum.
  task automatic test_triangle_floor();
    set_pot(CH_DEPTH, 10'd0);
    set_pot(CH_BASE, 10'd0);
    repeat (12) send_tick();
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int busy_pct);
    int sent;
    int len;
    int pick;
    int level;
    logic [CHAN_W-1:0] ch;
    send_idle_pct = idle_pct;
    stall_pct = busy_pct;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(1, 24);
        repeat (len) send_tick();
      end else if (pick < 85) begin
        // A run of samples on one pot, mostly the three with a role.
        pick = $urandom_range(9);
        if (pick < 3) ch = CH_BASE;
        else if (pick < 6) ch = CH_RATE;
        else if (pick < 8) ch = CH_DEPTH;
        else ch = CHAN_W'($urandom_range(7));
        pick = $urandom_range(3);
        if (pick == 0) level = 0;
        else if (pick == 1) level = 1023;
        else level = $urandom_range(1023);
        if (ch == CH_RATE && $urandom_range(1) == 1) level = $urandom_range(850, 1023);
        len = $urandom_range(4, 32);
        repeat (len) begin
          if ($urandom_range(7) == 0) send_sample(ch, SAMPLE_W'($urandom_range(1023)));
          else send_sample(ch, SAMPLE_W'(level));
        end
      end else begin
        len = 1;
        send_noise();
      end
      sent += len;
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    repeat (24) send_noise();
    wait_drained();
    repeat (8) send_noise();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("period", want.period, result.period);
        report_field("compare_value", 16'(want.compare_value), 16'(result.compare_value));
        report_field("period_changed", 16'(want.period_changed), 16'(result.period_changed));
        report_field("next_channel", 16'(want.next_channel), 16'(result.next_channel));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("triangle_lfo_with_pot_averaging_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    reset_lfo_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_and_extremes();
    test_rate_zero_count();
    test_fall_below_zero();
    test_triangle_floor();
    test_random_traffic(40, 0, 0);
    test_random_traffic(40, 84, 0);
    test_random_traffic(40, 0, 84);
    test_random_traffic(40, 34, 34);
    test_backpressure();
    stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("triangle_lfo_with_pot_averaging_unit regression: pass");
    end else begin
      $display("triangle_lfo_with_pot_averaging_unit regression: fail");
    end
    $finish;
  end

endmodule
